FILE: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Beat payload structs, register indexes and fixed byte constants.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // bytes held in each 64-bit text register (pattern, replacement)
   localparam int unsigned CFG_BYTES = 8;
   localparam int unsigned CFG_W     = 8 * CFG_BYTES;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned LEN_W     = 4;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_BYTES = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_payload_type;

endpackage

FILE: src/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace: byte stream find-and-replace
// Replaces leftmost, non-overlapping pattern occurrences, one text byte a beat.
// ----------------------------------------------------------------------------
// Each accepted request beat is resolved in the cycle it is taken: the partial
// match is advanced by the KMP rule and every result byte it causes (held
// bytes, the new byte, or the replacement text) is loaded into an output
// shift buffer, from which one response beat leaves per cycle while rsp_ready
// is high, starting the cycle after acceptance. A request is taken when that
// buffer is empty or is handing out its final byte in the same cycle, so a
// stream in which each byte causes at most one result runs at one byte per
// cycle while rsp_ready is high; a byte with more results holds input until
// its last result leaves. Bytes only held cause no response beat. Newline or
// end_of_stream flushes held bytes. Registers may be written only while idle.
module stream_find_replace
   import sfr_pkg::*;
#(
   parameter int unsigned MAX_PATTERN     = 8,
   parameter int unsigned MAX_REPLACEMENT = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   // register write port
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   // buffer depth covers the longest burst of results for one byte
   localparam int unsigned DEPTH =
      (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned K_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int unsigned IW    = K_W + 1;
   localparam int unsigned TXT_N = 2 ** K_W;

   // configuration registers
   logic [CFG_W-1:0] pat_ff, pat_in;
   logic [LEN_W-1:0] plen_ff, plen_in;
   logic [CFG_W-1:0] rep_ff, rep_in;
   logic [LEN_W-1:0] rlen_ff, rlen_in;

   // match state and output buffer
   logic [K_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       obuf_ff [DEPTH];
   logic [7:0]       obuf_in [DEPTH];

   // datapath
   logic [LEN_W-1:0] plen_eff, rlen_eff;
   logic [7:0]       pat_b [CFG_BYTES];
   logic [7:0]       rep_b [CFG_BYTES];
   logic [7:0]       txt [TXT_N];
   logic [IW-1:0]    total;
   logic [IW-1:0]    idx;
   logic [IW-1:0]    j_best;
   logic             cand_ok;
   logic             flush_case, hit;
   logic             req_take, rsp_take;
   logic [7:0]       c;
   logic             eos;
   logic [CNT_W-1:0] new_cnt;
   logic [K_W-1:0]   new_k;
   logic [7:0]       new_buf [DEPTH];

   assign c   = req_payload.in_byte;
   assign eos = req_payload.end_of_stream;

   // length limits
   assign plen_eff = (plen_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_ff;
   assign rlen_eff = (rlen_ff > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rlen_ff;

   // handshake
   assign rsp_valid = (cnt_ff != '0);
   assign req_ready = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;

   assign rsp_payload.out_byte    = obuf_ff[0];
   assign rsp_payload.last_of_run = (cnt_ff == CNT_W'(1));

   // text view: held bytes are the pattern prefix, followed by the new byte
   always_comb begin
      for (int i = 0; i < CFG_BYTES; i++) begin
         pat_b[i] = pat_ff[8*i +: 8];
         rep_b[i] = rep_ff[8*i +: 8];
      end
      for (int i = 0; i < TXT_N; i++) begin
         if ((i < CFG_BYTES) && (IW'(i) < IW'(k_ff)))
            txt[i] = pat_b[i % CFG_BYTES];
         else
            txt[i] = c;
      end
   end

   // longest suffix of held text plus new byte that is a pattern prefix
   always_comb begin
      total  = IW'(k_ff) + IW'(1);
      j_best = '0;
      idx    = '0;
      cand_ok = 1'b0;
      for (int j = 1; j <= MAX_PATTERN; j++) begin
         cand_ok = (IW'(j) <= total);
         for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i < j) begin
               idx = total - IW'(j) + IW'(i);
               if (txt[idx[K_W-1:0]] != pat_b[i])
                  cand_ok = 1'b0;
            end
         end
         if (cand_ok)
            j_best = IW'(j);
      end
   end

   // result selection and next match length
   always_comb begin
      flush_case = (c == NEWLINE_BYTE) || (LEN_W'(k_ff) >= plen_eff);
      hit        = !flush_case && (LEN_W'(j_best) == plen_eff);
      for (int b = 0; b < DEPTH; b++)
         new_buf[b] = 8'd0;
      if (hit) begin
         for (int b = 0; b < MAX_REPLACEMENT; b++)
            new_buf[b] = rep_b[b];
         new_cnt = CNT_W'(rlen_eff);
         new_k   = '0;
      end else begin
         for (int b = 0; b < MAX_PATTERN; b++)
            new_buf[b] = txt[b];
         if (flush_case || eos) begin
            new_cnt = CNT_W'(total);
            new_k   = '0;
         end else begin
            new_cnt = CNT_W'(total - j_best);
            new_k   = j_best[K_W-1:0];
         end
      end
   end

   // buffer load or shift
   always_comb begin
      k_in   = k_ff;
      cnt_in = cnt_ff;
      for (int b = 0; b < DEPTH; b++)
         obuf_in[b] = obuf_ff[b];
      if (req_take) begin
         k_in   = new_k;
         cnt_in = new_cnt;
         for (int b = 0; b < DEPTH; b++)
            obuf_in[b] = new_buf[b];
      end else if (rsp_take) begin
         cnt_in = cnt_ff - CNT_W'(1);
         for (int b = 0; b + 1 < DEPTH; b++)
            obuf_in[b] = obuf_ff[b+1];
      end
   end

   // register writes
   always_comb begin
      pat_in  = pat_ff;
      plen_in = plen_ff;
      rep_in  = rep_ff;
      rlen_in = rlen_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:      pat_in  = csr_wdata;
            CSR_PATTERN_LENGTH:     plen_in = csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  rep_in  = csr_wdata;
            CSR_REPLACEMENT_LENGTH: rlen_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         plen_ff <= '0;
         rep_ff  <= '0;
         rlen_ff <= '0;
         k_ff    <= '0;
         cnt_ff  <= '0;
      end else begin
         pat_ff  <= pat_in;
         plen_ff <= plen_in;
         rep_ff  <= rep_in;
         rlen_ff <= rlen_in;
         k_ff    <= k_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < DEPTH; b++)
         obuf_ff[b] <= obuf_in[b];
   end

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("result count beyond buffer depth");

   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && (c == NEWLINE_BYTE)) |=> (k_ff == '0))
      else $error("partial match survives newline");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && eos) |=> (k_ff == '0))
      else $error("partial match survives end of stream");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(cnt_ff) && $stable(k_ff)))
      else $error("buffer or match state moved during stall");

endmodule
